@@ rtl/lsbq_pkg.sv @@
// Package for the load/store buffer queue: sizes, op codes, modes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package lsbq_pkg;

  localparam int NumEntries = 8;
  localparam int TagBits    = 6;
  localparam int IdxBits    = $clog2(NumEntries);
  localparam int PosBits    = $clog2(NumEntries + 1);

  typedef enum logic [2:0] {
    OP_LW  = 3'd0,
    OP_LH  = 3'd1,
    OP_LHU = 3'd2,
    OP_LB  = 3'd3,
    OP_LBU = 3'd4,
    OP_SW  = 3'd5,
    OP_SH  = 3'd6,
    OP_SB  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    MODE_SNOOP     = 3'd0,
    MODE_ENQUEUE   = 3'd1,
    MODE_ISSUE_ADR = 3'd2,
    MODE_WRITE_ADR = 3'd3,
    MODE_ISSUE_LD  = 3'd4,
    MODE_FLUSH     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic execute;  // apply the latched word to the entries, register the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dummy_ok;
  } status_t;

  function automatic logic is_store(input logic [2:0] op);
    return (op == OP_SW) || (op == OP_SH) || (op == OP_SB);
  endfunction

endpackage

@@ rtl/lsbq_ctrl.sv @@
// Controller for the load/store buffer queue: input/output handshake sequencing.
// Depends on lsbq_pkg.
module lsbq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lsbq_pkg::cmd_t    cmd,
  input  lsbq_pkg::status_t status
);
  import lsbq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_HOLD;
      ST_HOLD: if (out_ready) state_next = in_valid ? ST_EXEC : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = status.dummy_ok;
        cmd.capture = in_valid && status.dummy_ok;
      end
      ST_EXEC: cmd.execute = 1'b1;
      ST_HOLD: begin
        out_valid   = 1'b1;
        in_ready    = out_ready;
        cmd.capture = out_ready && in_valid;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/lsbq_dp.sv @@
// Datapath for the load/store buffer queue: entry storage, queue positions and
// result register. Depends on lsbq_pkg.
module lsbq_dp (
  input  logic              clk,
  input  logic              rst,
  input  lsbq_pkg::cmd_t    cmd,
  output lsbq_pkg::status_t status,
  input  logic [7:0]        entry_base,
  input  logic [173:0]      in_word,
  output logic [127:0]      out_word
);
  import lsbq_pkg::*;

  // Latched input fields
  logic [173:0] word;
  logic [2:0]   f_mode, f_op;
  logic [5:0]   f_tag_j, f_tag_k, f_rob, f_cdb_tag;
  logic [31:0]  f_val_j, f_val_k, f_addr, f_cdb_val;
  logic [7:0]   f_id, f_mask;

  assign f_mode    = word[2:0];
  assign f_op      = word[5:3];
  assign f_tag_j   = word[11:6];
  assign f_tag_k   = word[17:12];
  assign f_val_j   = word[49:18];
  assign f_val_k   = word[81:50];
  assign f_addr    = word[113:82];
  assign f_rob     = word[119:114];
  assign f_id      = word[127:120];
  assign f_cdb_tag = word[133:128];
  assign f_cdb_val = word[165:134];
  assign f_mask    = word[173:166];

  // Entry storage
  logic                 busy  [NumEntries];
  logic                 known [NumEntries];
  logic [PosBits-1:0]   qpos  [NumEntries];
  logic [2:0]           e_op  [NumEntries];
  logic [TagBits-1:0]   e_tj  [NumEntries];
  logic [TagBits-1:0]   e_tk  [NumEntries];
  logic [31:0]          e_vj  [NumEntries];
  logic [31:0]          e_vk  [NumEntries];
  logic [31:0]          e_ad  [NumEntries];
  logic [5:0]           e_rob [NumEntries];
  logic [PosBits-1:0]   total;

  assign status.dummy_ok = 1'b1;

  // Selection logic
  logic               free_hit, ld_hit, adr_hit, adr_store, id_hit;
  logic [IdxBits-1:0] free_idx, ld_idx, adr_idx, id_idx;
  logic               head_store_blk;
  logic [PosBits-1:0] best_pos;

  always_comb begin
    free_hit = 1'b0; free_idx = '0;
    ld_hit = 1'b0; ld_idx = '0;
    id_hit = 1'b0; id_idx = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_hit = 1'b1; free_idx = IdxBits'(i);
      end
      if (busy[i] && !is_store(e_op[i]) && qpos[i] == '0 && known[i] && !f_mask[i]) begin
        ld_hit = 1'b1; ld_idx = IdxBits'(i);
      end
      if (8'(entry_base + 8'(i)) == f_id) begin
        id_hit = 1'b1; id_idx = IdxBits'(i);
      end
    end
  end

  // Address issue: earliest queued entry that is a store or a ready load
  always_comb begin
    adr_hit = 1'b0; adr_idx = '0; adr_store = 1'b0; best_pos = '1;
    head_store_blk = 1'b0;
    for (int i = 0; i < NumEntries; i++) begin
      if (busy[i] && qpos[i] != '0 && (is_store(e_op[i]) || e_tj[i] == '0)
          && qpos[i] < best_pos) begin
        best_pos = qpos[i]; adr_idx = IdxBits'(i);
      end
    end
    if (best_pos != '1) begin
      adr_store = is_store(e_op[adr_idx]);
      adr_hit   = !adr_store || (best_pos == PosBits'(1) && e_tj[adr_idx] == '0);
    end
    head_store_blk = adr_store;
  end

  // Result fields
  logic               found;
  logic [IdxBits-1:0] sel;
  logic               all_next;

  always_comb begin
    found = 1'b0; sel = '0;
    if (f_mode == MODE_ISSUE_ADR) begin
      found = adr_hit; sel = adr_idx;
    end else if (f_mode == MODE_ISSUE_LD) begin
      found = ld_hit; sel = ld_idx;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word <= in_word;
    end
  end

  // Entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumEntries; i++) begin
        busy[i] <= 1'b0; known[i] <= 1'b0; qpos[i] <= '0;
      end
      total <= '0;
    end else if (cmd.execute) begin
      case (f_mode)
        MODE_SNOOP: begin
          if (TagBits'(f_cdb_tag) != '0) begin
            for (int i = 0; i < NumEntries; i++) begin
              if (busy[i] && e_tj[i] == TagBits'(f_cdb_tag)) begin
                e_vj[i] <= f_cdb_val; e_tj[i] <= '0;
              end
              if (busy[i] && e_tk[i] == TagBits'(f_cdb_tag)) begin
                e_vk[i] <= f_cdb_val; e_tk[i] <= '0;
              end
            end
          end
        end
        MODE_ENQUEUE: begin
          if (free_hit) begin
            busy[free_idx]  <= 1'b1;
            known[free_idx] <= 1'b0;
            e_op[free_idx]  <= f_op;
            e_tj[free_idx]  <= TagBits'(f_tag_j);
            e_tk[free_idx]  <= TagBits'(f_tag_k);
            e_vj[free_idx]  <= f_val_j;
            e_vk[free_idx]  <= f_val_k;
            e_ad[free_idx]  <= f_addr;
            e_rob[free_idx] <= f_rob;
            qpos[free_idx]  <= total + PosBits'(1);
            total           <= total + PosBits'(1);
          end
        end
        MODE_ISSUE_ADR: begin
          if (adr_hit) begin
            for (int i = 0; i < NumEntries; i++) begin
              if (busy[i] && qpos[i] > best_pos) qpos[i] <= qpos[i] - PosBits'(1);
            end
            qpos[adr_idx] <= '0;
            total <= total - PosBits'(1);
            if (head_store_blk) busy[adr_idx] <= 1'b0;
          end
        end
        MODE_WRITE_ADR: begin
          if (id_hit && busy[id_idx] && qpos[id_idx] == '0 && !known[id_idx]) begin
            e_ad[id_idx]  <= f_addr;
            known[id_idx] <= 1'b1;
          end
        end
        MODE_ISSUE_LD: begin
          if (ld_hit) begin
            busy[ld_idx] <= 1'b0; known[ld_idx] <= 1'b0;
          end
        end
        MODE_FLUSH: begin
          for (int i = 0; i < NumEntries; i++) begin
            busy[i] <= 1'b0; known[i] <= 1'b0; qpos[i] <= '0;
          end
          total <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result register; full flag and queue count are read after the update lands
  logic [119:0] res;
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (found) begin
        res <= {e_rob[sel], e_ad[sel], e_vk[sel], 6'(e_tk[sel]), e_vj[sel],
                e_op[sel], 8'(entry_base + 8'(sel)), 1'b1};
      end else begin
        res <= '0;
      end
    end
  end

  always_comb begin
    all_next = 1'b1;
    for (int i = 0; i < NumEntries; i++) if (!busy[i]) all_next = 1'b0;
  end

  assign out_word = {3'd0, total, all_next, res};

endmodule

@@ rtl/load_store_buffer_queue.sv @@
// Top level of the load/store buffer queue. Instantiates controller and datapath,
// followed by the port checker and its bind. Depends on lsbq_pkg, lsbq_ctrl, lsbq_dp.
//
// Eight-entry load/store buffer. Each input word is one operation (snoop,
// enqueue, address issue, address write, load issue, flush) and yields exactly
// one output word. The accepted word is captured, then executed, and the result
// is offered after that. The next word is taken in the cycle the result is
// taken, so no new word is taken while a result waits, as set by the single
// capture/execute sequence of the controller. The user must write the entry
// base register through the cfg port while idle; the block does not enforce it.
module load_store_buffer_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, op_kind, tag_j, tag_k, value_j, value_k, addr_word, rob_tag, entry_id,
  // cdb_tag, cdb_value, conflict_mask
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found, out_entry_id, out_op, out_value_j, out_tag_k, out_value_k, out_addr,
  // out_rob_tag, full, queue_count
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import lsbq_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [7:0]  entry_base;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_base <= '0;
    end else if (cfg_valid) begin
      entry_base <= cfg_data;
    end
  end

  lsbq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd, .status
  );

  lsbq_dp u_dp (
    .clk, .rst, .cmd, .status, .entry_base,
    .in_word (s_axis_tdata[173:0]),
    .out_word(m_axis_tdata)
  );

endmodule

// Port checker for the load/store buffer queue
module lsbq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)));

  // no input is taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready));

  // an accepted word is executed before its result shows
  a_exec: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid);

  // padding is zero and the queue count stays in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[127:125] == 3'd0 && m_axis_tdata[124:121] <= 4'd8));

endmodule

bind load_store_buffer_queue lsbq_checker i_chk (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ test/tb.sv @@
// Self-checking testbench for load_store_buffer_queue: directed and random operation streams.
// A built-in predictor of the buffer state checks every result word. Depends on lsbq_pkg.
`timescale 1ns / 1ps

module tb;
  import lsbq_pkg::*;

  localparam logic [2:0] MODE_UNUSED_A = 3'd6;
  localparam logic [2:0] MODE_UNUSED_B = 3'd7;
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 1500;

  // input word, last field in the top bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  conflict_mask;
    logic [31:0] cdb_value;
    logic [5:0]  cdb_tag;
    logic [7:0]  entry_id;
    logic [5:0]  rob_tag;
    logic [31:0] addr_word;
    logic [31:0] value_k;
    logic [31:0] value_j;
    logic [5:0]  tag_k;
    logic [5:0]  tag_j;
    logic [2:0]  op_kind;
    logic [2:0]  mode;
  } lsq_cmd_t;

  // result word
  typedef struct packed {
    logic [2:0]  pad;
    logic [3:0]  queue_count;
    logic        full;
    logic [5:0]  rob_tag;
    logic [31:0] addr;
    logic [31:0] value_k;
    logic [5:0]  tag_k;
    logic [31:0] value_j;
    logic [2:0]  op;
    logic [7:0]  entry_id;
    logic        found;
  } lsq_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;  // mode, op_kind, tag_j, tag_k, value_j, value_k, addr_word,
                                    // rob_tag, entry_id, cdb_tag, cdb_value, conflict_mask
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // found, out_entry_id, out_op, out_value_j, out_tag_k,
                                    // out_value_k, out_addr, out_rob_tag, full, queue_count
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;

  load_store_buffer_queue i_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #4 clk = ~clk;

  // predicted buffer state
  logic        busy_q [NumEntries];
  logic [2:0]  op_q [NumEntries];
  logic [5:0]  tagj_q [NumEntries];
  logic [5:0]  tagk_q [NumEntries];
  logic [31:0] valj_q [NumEntries];
  logic [31:0] valk_q [NumEntries];
  logic [31:0] addr_q [NumEntries];
  logic [5:0]  rob_q [NumEntries];
  logic [3:0]  qpos_q [NumEntries];
  logic        known_q [NumEntries];
  logic [3:0]  queued_q;
  logic [7:0]  id_base;

  lsq_res_t pending_results [$];
  int errors, words_sent, words_checked, issues_seen, cycles;
  logic quiet;

  function automatic logic store_op(logic [2:0] op);
    return op == OP_SW || op == OP_SH || op == OP_SB;
  endfunction

  function automatic void clear_buffer();
    for (int i = 0; i < NumEntries; i++) begin
      busy_q[i] = '0; op_q[i] = '0; tagj_q[i] = '0; tagk_q[i] = '0; valj_q[i] = '0;
      valk_q[i] = '0; addr_q[i] = '0; rob_q[i] = '0; qpos_q[i] = '0; known_q[i] = '0;
    end
    queued_q = '0;
  endfunction

  function automatic void show_entry(inout lsq_res_t r, input int i);
    r.found = 1'b1; r.entry_id = id_base + 8'(i); r.op = op_q[i]; r.value_j = valj_q[i];
    r.tag_k = tagk_q[i]; r.value_k = valk_q[i]; r.addr = addr_q[i]; r.rob_tag = rob_q[i];
  endfunction

  // take entry i out of the address queue, closing the gap
  function automatic void dequeue_entry(int i);
    logic [3:0] pos;
    pos = qpos_q[i];
    qpos_q[i] = '0;
    for (int k = 0; k < NumEntries; k++)
      if (busy_q[k] && qpos_q[k] > pos) qpos_q[k]--;
    if (queued_q > 0) queued_q--;
  endfunction

  // apply one operation to the predicted buffer and return the result word
  function automatic lsq_res_t buffer_step(lsq_cmd_t c);
    lsq_res_t r;
    int e;
    logic all;
    r = '0;
    case (c.mode)
      MODE_SNOOP: begin
        if (c.cdb_tag != '0)
          for (int i = 0; i < NumEntries; i++) begin
            if (!busy_q[i]) continue;
            if (tagj_q[i] == c.cdb_tag) begin valj_q[i] = c.cdb_value; tagj_q[i] = '0; end
            if (tagk_q[i] == c.cdb_tag) begin valk_q[i] = c.cdb_value; tagk_q[i] = '0; end
          end
      end
      MODE_ENQUEUE: begin
        for (int i = 0; i < NumEntries; i++)
          if (!busy_q[i]) begin
            busy_q[i] = 1'b1; op_q[i] = c.op_kind; tagj_q[i] = c.tag_j; tagk_q[i] = c.tag_k;
            valj_q[i] = c.value_j; valk_q[i] = c.value_k; addr_q[i] = c.addr_word;
            rob_q[i] = c.rob_tag; known_q[i] = 1'b0;
            queued_q++;
            qpos_q[i] = queued_q;
            break;
          end
      end
      MODE_ISSUE_ADR: begin
        for (int p = 1; p <= queued_q; p++) begin
          e = -1;
          for (int k = 0; k < NumEntries; k++)
            if (e < 0 && busy_q[k] && qpos_q[k] == p) e = k;
          if (e < 0) break;
          if (store_op(op_q[e])) begin
            // a store goes only from the head, and is retired here
            if (p == 1 && tagj_q[e] == '0) begin
              show_entry(r, e);
              dequeue_entry(e);
              busy_q[e] = 1'b0;
            end
            break;
          end
          if (tagj_q[e] == '0) begin
            show_entry(r, e);
            dequeue_entry(e);
            break;
          end
        end
      end
      MODE_WRITE_ADR: begin
        for (int i = 0; i < NumEntries; i++)
          if (id_base + 8'(i) == c.entry_id) begin
            if (busy_q[i] && qpos_q[i] == '0 && !known_q[i]) begin
              addr_q[i] = c.addr_word;
              known_q[i] = 1'b1;
            end
            break;
          end
      end
      MODE_ISSUE_LD: begin
        for (int i = 0; i < NumEntries; i++)
          if (busy_q[i] && !store_op(op_q[i]) && qpos_q[i] == '0 && known_q[i]
              && !c.conflict_mask[i]) begin
            show_entry(r, i);
            busy_q[i] = 1'b0;
            known_q[i] = 1'b0;
            break;
          end
      end
      MODE_FLUSH: clear_buffer();
      default: ;
    endcase
    all = 1'b1;
    for (int i = 0; i < NumEntries; i++)
      if (!busy_q[i]) all = 1'b0;
    r.full = all;
    r.queue_count = queued_q;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    lsq_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report("unexpected result word", 32'(got.entry_id), 32'd0);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (want.found) issues_seen++;
        if (got.found != want.found) report("found", 32'(got.found), 32'(want.found));
        if (got.entry_id != want.entry_id)
          report("entry_id", 32'(got.entry_id), 32'(want.entry_id));
        if (got.op != want.op) report("op", 32'(got.op), 32'(want.op));
        if (got.value_j != want.value_j) report("value_j", got.value_j, want.value_j);
        if (got.tag_k != want.tag_k) report("tag_k", 32'(got.tag_k), 32'(want.tag_k));
        if (got.value_k != want.value_k) report("value_k", got.value_k, want.value_k);
        if (got.addr != want.addr) report("addr", got.addr, want.addr);
        if (got.rob_tag != want.rob_tag)
          report("rob_tag", 32'(got.rob_tag), 32'(want.rob_tag));
        if (got.full != want.full) report("full", 32'(got.full), 32'(want.full));
        if (got.queue_count != want.queue_count)
          report("queue_count", 32'(got.queue_count), 32'(want.queue_count));
        if (got.pad != '0) report("padding", 32'(got.pad), 32'd0);
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // send one word; valid stays high into the next call
  task automatic send_word(lsq_cmd_t c);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tdata = c;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(buffer_step(c));
    words_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_id_base(logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    id_base = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic lsq_cmd_t op_word(logic [2:0] mode);
    lsq_cmd_t c;
    c = '0;
    c.mode = mode;
    return c;
  endfunction

  function automatic lsq_cmd_t enq_word(logic [2:0] op, logic [5:0] tj, logic [5:0] tk,
                                        logic [31:0] vj, logic [31:0] vk, logic [31:0] a,
                                        logic [5:0] rob);
    lsq_cmd_t c;
    c = op_word(MODE_ENQUEUE);
    c.op_kind = op; c.tag_j = tj; c.tag_k = tk; c.value_j = vj; c.value_k = vk;
    c.addr_word = a; c.rob_tag = rob;
    return c;
  endfunction

  // idle buffer: issues find nothing, no-op modes change nothing
  task automatic test_empty_buffer();
    lsq_cmd_t c;
    send_word(op_word(MODE_ISSUE_ADR));
    send_word(op_word(MODE_ISSUE_LD));
    c = op_word(MODE_SNOOP);
    c.cdb_value = 32'hFFFF_FFFF;
    send_word(c);
    send_word(op_word(MODE_UNUSED_A));
    send_word(op_word(MODE_UNUSED_B));
  endtask

  // fill all entries, overflow, stalled store at the head, address and load flow
  task automatic test_fill_and_issue();
    lsq_cmd_t c;
    send_word(enq_word(OP_LW, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'd0, 32'h10, 6'd63));
    send_word(enq_word(OP_SW, 6'd63, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0));
    for (int k = 1; k < 7; k++)
      send_word(enq_word(3'(k + 1), 6'(k), 6'(k), $urandom, $urandom, $urandom, 6'(k)));
    // buffer full, dropped
    send_word(enq_word(OP_LB, 6'd0, 6'd0, 32'd1, 32'd2, 32'd3, 6'd4));
    send_word(op_word(MODE_ISSUE_ADR));            // load at the head
    send_word(op_word(MODE_ISSUE_ADR));            // store head waits on its base
    c = op_word(MODE_SNOOP);
    c.cdb_tag = 6'd63;
    c.cdb_value = 32'hA5A5_5A5A;
    send_word(c);
    send_word(op_word(MODE_ISSUE_ADR));            // store now leaves
    c = op_word(MODE_WRITE_ADR);
    c.entry_id = 8'd200;                           // no such entry
    send_word(c);
    c.entry_id = 8'd2;                             // still queued
    send_word(c);
    c.entry_id = 8'd0;
    c.addr_word = 32'hFFFF_FFFC;
    send_word(c);
    send_word(c);                                  // repeated write; at id base 0 the address is already known
    c = op_word(MODE_ISSUE_LD);
    c.conflict_mask = 8'hFF;
    send_word(c);
    c.conflict_mask = 8'h00;
    send_word(c);
    send_word(op_word(MODE_FLUSH));
  endtask

  function automatic logic [5:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return '0;
    if (r < 90) return 6'($urandom_range(1, 7));
    return 6'($urandom);
  endfunction

  // mostly well-formed traffic with random contents
  function automatic lsq_cmd_t random_word();
    lsq_cmd_t c;
    int r, slot;
    c = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    c.pad = '0;
    c.mode = MODE_SNOOP;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      c.mode = MODE_ENQUEUE;
      c.tag_j = pick_tag();
      c.tag_k = pick_tag();
    end else if (r < 50) begin
      c.cdb_tag = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 7));
    end else if (r < 70) begin
      c.mode = MODE_ISSUE_ADR;
    end else if (r < 85) begin
      c.mode = MODE_WRITE_ADR;
      slot = -1;
      for (int i = 0; i < NumEntries; i++)
        if (busy_q[i] && qpos_q[i] == '0 && !known_q[i] && $urandom_range(0, 1)) slot = i;
      if (slot >= 0 && $urandom_range(0, 9) < 8) c.entry_id = id_base + 8'(slot);
    end else if (r < 97) begin
      c.mode = MODE_ISSUE_LD;
      if ($urandom_range(0, 9) < 6) c.conflict_mask = '0;
    end else if (r < 98) begin
      c.mode = MODE_FLUSH;
    end else begin
      c.mode = $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
    end
    return c;
  endfunction

  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);
      if (n == count * 3 / 4) wait_idle();  // sender holds until all results are back
      send_word(random_word());
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0; issues_seen = 0; cycles = 0;
    quiet = 1'b0;
    id_base = '0;
    clear_buffer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_buffer();
    test_fill_and_issue();
    set_id_base(8'd255);
    test_fill_and_issue();
    test_random_traffic(RandomItems / 4);
    set_id_base(8'd250);
    test_random_traffic(RandomItems / 4);
    set_id_base(8'($urandom));
    test_random_traffic(RandomItems / 4);
    set_id_base(8'd0);
    test_random_traffic(RandomItems / 4);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d of them issued entries",
             words_sent, words_checked, issues_seen);
    $display("covered empty, full and flushed buffer, store ordering and four id bases");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
